/* design/b64q_pkg.sv */
// b64q_pkg: shared types, codes and the character map for the base64 quad decoder.
// No dependencies.
package b64q_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_BAD_LENGTH   = 2'd1;
  localparam logic [1:0] STATUS_BAD_CHAR     = 2'd2;
  localparam logic [1:0] STATUS_PAD_MISMATCH = 2'd3;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] COUNT_EMPTY = 3'd0;
  localparam logic [2:0] COUNT_FULL  = 3'd4;

  // mask bits of a queued word: three data bytes then the closing status
  localparam int MASK_D0     = 0;
  localparam int MASK_D1     = 1;
  localparam int MASK_D2     = 2;
  localparam int MASK_STATUS = 3;

  typedef struct packed {
    logic [3:0] mask;
    logic [7:0] data0;
    logic [7:0] data1;
    logic [7:0] data2;
    logic [1:0] status;
  } rec_t;

  typedef struct packed {
    logic       invalid;
    logic [5:0] value;
  } sextet_t;

  function automatic sextet_t sextet(input logic [7:0] ch);
    sextet_t s;
    logic [7:0] t;
    s = '{invalid: 1'b0, value: 6'd0};
    t = 8'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      t = ch - 8'd65;
      s.value = t[5:0];
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      t = ch - 8'd71;
      s.value = t[5:0];
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      t = ch + 8'd4;
      s.value = t[5:0];
    end else if (ch == 8'h2B) begin
      s.value = 6'd62;
    end else if (ch == 8'h2F) begin
      s.value = 6'd63;
    end else begin
      s.invalid = 1'b1;
    end
    return s;
  endfunction

endpackage

/* design/b64q_front.sv */
// b64q_front: accepts quads, maps characters, tracks error and padding state,
// and builds one queued word per item that yields results. Uses b64q_pkg.
module b64q_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       text0,
  input  logic [7:0]       text1,
  input  logic [7:0]       text2,
  input  logic [7:0]       text3,
  input  logic [2:0]       text_count,
  input  logic             last_quad,
  input  logic             q_full,
  output logic             q_write,
  output b64q_pkg::rec_t   q_data
);

  logic [1:0] fail_code, fail_code_next;
  logic [1:0] skipped_bytes, skipped_bytes_next;
  logic [1:0] final_pad, final_pad_next;

  b64q_pkg::sextet_t sa, sb, sc, sd;
  logic       accept, is_quad, bad_len, pad2, pad3, bad, emit;
  logic [2:0] skip_sum;
  logic [1:0] pad_cnt, c_low, end_status;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    sa = b64q_pkg::sextet(text0);
    sb = b64q_pkg::sextet(text1);
    sc = b64q_pkg::sextet(text2);
    sd = b64q_pkg::sextet(text3);
    pad2 = (text2 == b64q_pkg::PAD_CHAR);
    pad3 = (text3 == b64q_pkg::PAD_CHAR);
    is_quad = (text_count == b64q_pkg::COUNT_FULL);
    bad_len = !is_quad && (text_count != b64q_pkg::COUNT_EMPTY);
    bad = sa.invalid || sb.invalid || (sc.invalid && !pad2) || (sd.invalid && !pad3);
    emit = is_quad && !bad && (fail_code == b64q_pkg::STATUS_OK);

    fail_code_next = fail_code;
    if (is_quad && bad && fail_code == b64q_pkg::STATUS_OK)
      fail_code_next = b64q_pkg::STATUS_BAD_CHAR;
    if (bad_len)
      fail_code_next = b64q_pkg::STATUS_BAD_LENGTH;

    pad_cnt  = {1'b0, pad2} + {1'b0, pad3};
    skip_sum = {1'b0, skipped_bytes} + {1'b0, pad_cnt};
    skipped_bytes_next = skipped_bytes;
    final_pad_next     = final_pad;
    if (is_quad) begin
      skipped_bytes_next = skip_sum[2] ? 2'd3 : skip_sum[1:0];
      final_pad_next     = pad_cnt;
    end

    end_status = fail_code_next;
    if (end_status == b64q_pkg::STATUS_OK && skipped_bytes_next != final_pad_next)
      end_status = b64q_pkg::STATUS_PAD_MISMATCH;

    c_low = pad2 ? 2'b11 : sc.value[1:0];
    q_data.mask[b64q_pkg::MASK_D0]     = emit;
    q_data.mask[b64q_pkg::MASK_D1]     = emit && !pad2;
    q_data.mask[b64q_pkg::MASK_D2]     = emit && !pad3;
    q_data.mask[b64q_pkg::MASK_STATUS] = last_quad;
    q_data.data0  = {sa.value, sb.value[5:4]};
    q_data.data1  = {sb.value[3:0], sc.value[5:2]};
    q_data.data2  = {c_low, sd.value};
    q_data.status = end_status;

    q_write = accept && (q_data.mask != 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fail_code     <= b64q_pkg::STATUS_OK;
      skipped_bytes <= 2'd0;
      final_pad     <= 2'd0;
    end else if (accept) begin
      if (last_quad) begin
        fail_code     <= b64q_pkg::STATUS_OK;
        skipped_bytes <= 2'd0;
        final_pad     <= 2'd0;
      end else begin
        fail_code     <= fail_code_next;
        skipped_bytes <= skipped_bytes_next;
        final_pad     <= final_pad_next;
      end
    end
  end

endmodule

/* design/b64q_fifo.sv */
// b64q_fifo: short queue of decoded words between front and back.
// Uses b64q_pkg for the word type.
module b64q_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  b64q_pkg::rec_t wr_data,
  input  logic           rd_en,
  output b64q_pkg::rec_t rd_data,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64q_pkg::rec_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= bump(wr_ptr);
      if (rd_en) rd_ptr <= bump(rd_ptr);
      if (wr_en && !rd_en)      count <= count + CNT_W'(1);
      else if (rd_en && !wr_en) count <= count - CNT_W'(1);
    end
  end

endmodule

/* design/b64q_back.sv */
// b64q_back: takes queued words and hands out their results one per cycle while pop is held.
// Uses b64q_pkg.
module b64q_back (
  input  logic           clk,
  input  logic           rst,
  input  b64q_pkg::rec_t q_data,
  input  logic           q_empty,
  output logic           q_read,
  output logic           empty,
  input  logic           pop,
  output logic           result_kind,
  output logic [7:0]     data_byte,
  output logic [1:0]     status,
  output logic           last_result
);

  b64q_pkg::rec_t cur;
  logic [3:0]     mask_after;
  logic           taken;

  assign empty      = (cur.mask == 4'd0);
  assign taken      = pop && !empty;
  assign mask_after = cur.mask & (cur.mask - 4'd1);
  assign q_read     = !q_empty && (empty || (taken && mask_after == 4'd0));

  always_comb begin
    result_kind = b64q_pkg::KIND_DATA;
    data_byte   = 8'd0;
    status      = b64q_pkg::STATUS_OK;
    last_result = 1'b0;
    priority if (cur.mask[b64q_pkg::MASK_D0]) begin
      data_byte = cur.data0;
    end else if (cur.mask[b64q_pkg::MASK_D1]) begin
      data_byte = cur.data1;
    end else if (cur.mask[b64q_pkg::MASK_D2]) begin
      data_byte = cur.data2;
    end else begin
      result_kind = b64q_pkg::KIND_STATUS;
      status      = cur.status;
      last_result = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.mask <= 4'd0;
    end else if (q_read) begin
      cur <= q_data;
    end else if (taken) begin
      cur.mask <= mask_after;
    end
  end

endmodule

/* design/base64_quad_decoder.sv */
// base64_quad_decoder: top level; front classifier, word queue, result sequencer.
// Depends on b64q_pkg, b64q_front, b64q_fifo, b64q_back.
//
//   channel   handshake      fields
//   input     push / full    text0..text3, text_count, last_quad
//   result    empty / pop    result_kind, data_byte, status, last_result
//
// The front takes one quad per cycle while the queue has room; the back
// sends one result per cycle while pop is held; a quad yields up to three
// data bytes, plus the closing status on the last quad.
// Reset clears the string state and empties the queue.
// A stalled result side backs up into the queue, then raises full.
module base64_quad_decoder #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text0,
  input  logic [7:0] text1,
  input  logic [7:0] text2,
  input  logic [7:0] text3,
  input  logic [2:0] text_count,
  input  logic       last_quad,
  output logic       empty,
  input  logic       pop,
  output logic       result_kind,
  output logic [7:0] data_byte,
  output logic [1:0] status,
  output logic       last_result
);

  b64q_pkg::rec_t wr_data, rd_data;
  logic q_write, q_read, q_full, q_empty;

  b64q_front u_front (
    .clk, .rst, .push, .full,
    .text0, .text1, .text2, .text3, .text_count, .last_quad,
    .q_full  (q_full),
    .q_write (q_write),
    .q_data  (wr_data)
  );

  b64q_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk, .rst,
    .wr_en   (q_write),
    .wr_data (wr_data),
    .rd_en   (q_read),
    .rd_data (rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  b64q_back u_back (
    .clk, .rst,
    .q_data  (rd_data),
    .q_empty (q_empty),
    .q_read  (q_read),
    .empty, .pop, .result_kind, .data_byte, .status, .last_result
  );

endmodule
